>>> hdl/countdown_timer_slot_pool_macros.svh
// assertion macros for the countdown timer slot pool
// used by the back end; expects clk_i and rst_ni in scope
`ifndef COUNTDOWN_TIMER_SLOT_POOL_MACROS_SVH
`define COUNTDOWN_TIMER_SLOT_POOL_MACROS_SVH

// a implies c in the same cycle
`define CTSP_ASSERT_IMPLIES(label, a, c, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error(msg);

// a implies c in the next cycle
`define CTSP_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error(msg);

`endif

>>> hdl/ctsp_pkg.sv
// shared types and constants of the countdown timer slot pool
// no dependencies
`default_nettype none

package ctsp_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int CMD_DEPTH     = 2;
  localparam int RES_DEPTH     = 4;

  localparam logic [29:0] CNT_MAX     = 30'h3fffffff;
  localparam logic [29:0] CNT_WRAP_TO = 30'd10000;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_POLL  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_START     = 3'd1,
    OP_BAD_START = 3'd2,
    OP_TICK      = 3'd3,
    OP_POLL      = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    EV_ALLOC = 3'd0,
    EV_FULL  = 3'd1,
    EV_START = 3'd2,
    EV_FIRE  = 3'd3,
    EV_RUN   = 3'd4,
    EV_DONE  = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  slot;
    logic [31:0] delay;
    logic        fast;
  } cmd_t;

  typedef struct packed {
    event_e      ev;
    logic [2:0]  slot_index;
    logic [29:0] tick_count;
    logic        wrapped;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/countdown_timer_slot_pool.sv
// channel   | handshake          | words
// ----------+--------------------+------------------------------------------------
// input     | push / full        | kind_i, slot_i, delay_i, fast_mode_i
// results   | pop / empty        | event_res_o, slot_index_o, tick_count_o,
//           |                    | wrapped_o, last_o
//
// allocate and start pass through the command queue and are done in the idle state of the back end
// tick and poll take a setup step in the idle state, a walk over every slot, and a done step
// the walk over the slot state in the back end sets the rate of ticks and polls
// reset clears all slots and the tick counter; no clearing pass
// a full result queue stalls the back end; a full command queue raises full
// top level: top of the countdown timer slot pool
// depends on ctsp_pkg, ctsp_front, ctsp_fifo, ctsp_back
`default_nettype none

module countdown_timer_slot_pool
  import ctsp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [31:0] delay_i,
  input  wire logic        fast_mode_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       event_res_o,
  output logic [2:0]       slot_index_o,
  output logic [29:0]      tick_count_o,
  output logic             wrapped_o,
  output logic             last_o
);

  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t res_in, res_head;
  logic res_push, res_full;

  ctsp_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .slot_i     (slot_i),
    .delay_i    (delay_i),
    .fast_mode_i(fast_mode_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  ctsp_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head),
    .empty_o(cmd_empty)
  );

  ctsp_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  ctsp_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head),
    .empty_o(empty)
  );

  assign event_res_o  = res_head.ev;
  assign slot_index_o = res_head.slot_index;
  assign tick_count_o = res_head.tick_count;
  assign wrapped_o    = res_head.wrapped;
  assign last_o       = res_head.last;

endmodule

`default_nettype wire

>>> hdl/ctsp_fifo.sv
// small first-in first-out queue of words, power-of-two depth
// no dependencies
`default_nettype none

module ctsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW + 1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ctsp_front.sv
// front end: takes input words and classifies them into commands
// depends on ctsp_pkg
`default_nettype none

module ctsp_front
  import ctsp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [31:0] delay_i,
  input  wire logic        fast_mode_i,
  input  wire logic        cmd_full_i,
  output logic             cmd_push_o,
  output cmd_t             cmd_o
);

  assign full       = cmd_full_i;
  assign cmd_push_o = push && !cmd_full_i;

  always_comb begin
    cmd_o.slot  = slot_i;
    cmd_o.delay = delay_i;
    cmd_o.fast  = fast_mode_i;
    case (kind_e'(kind_i))
      KIND_ALLOC: cmd_o.op = OP_ALLOC;
      KIND_START: cmd_o.op = (int'(slot_i) >= NUM_SLOTS) ? OP_BAD_START : OP_START;
      KIND_TICK:  cmd_o.op = OP_TICK;
      KIND_POLL:  cmd_o.op = OP_POLL;
      default:    cmd_o.op = OP_POLL;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/ctsp_back.sv
// back end: slot state, tick counter and the slot walk for ticks and polls
// depends on ctsp_pkg and the assertion macro header
`default_nettype none
`include "countdown_timer_slot_pool_macros.svh"

module ctsp_back
  import ctsp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_empty_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  state_e                 state_q, state_d;
  logic [NUM_SLOTS-1:0]   occupied_q, occupied_d;
  logic [NUM_SLOTS-1:0]   armed_q, armed_d;
  logic [NUM_SLOTS-1:0]   fast_q, fast_d;
  logic [31:0]            remaining_q [NUM_SLOTS];
  logic [29:0]            cnt_q, cnt_d;
  logic                   wrap_q, wrap_d;
  logic [SW-1:0]          idx_q, idx_d;

  logic                   rem_we;
  logic [SW-1:0]          rem_waddr;
  logic [31:0]            rem_wdata;
  logic                   free_found;
  logic [SW-1:0]          free_idx;
  logic [SW+2:0]          slot_ext;
  logic [SW-1:0]          start_idx;
  logic [SW+2:0]          idx_ext;
  logic [SW+2:0]          free_ext;
  logic [31:0]            cur_rem, rem_dec;
  logic                   need_push;
  logic                   walk_cmd_ok;
  logic                   walk_begin;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!occupied_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign slot_ext  = {{SW{1'b0}}, cmd_i.slot};
  assign start_idx = slot_ext[SW-1:0];
  assign idx_ext   = {3'b000, idx_q};
  assign free_ext  = {3'b000, free_idx};
  assign cur_rem   = remaining_q[idx_q];
  assign rem_dec   = cur_rem - 32'(cur_rem != '0);

  always_comb begin
    state_d    = state_q;
    occupied_d = occupied_q;
    armed_d    = armed_q;
    fast_d     = fast_q;
    cnt_d      = cnt_q;
    wrap_d     = wrap_q;
    idx_d      = idx_q;
    rem_we     = 1'b0;
    rem_waddr  = idx_q;
    rem_wdata  = rem_dec;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    need_push  = 1'b0;
    res_o.ev         = EV_DONE;
    res_o.slot_index = 3'd0;
    res_o.tick_count = cnt_q;
    res_o.wrapped    = wrap_q;
    res_o.last       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            OP_ALLOC: begin
              if (!res_full_i) begin
                res_push_o    = 1'b1;
                cmd_pop_o     = 1'b1;
                res_o.wrapped = 1'b0;
                res_o.last    = 1'b1;
                if (free_found) begin
                  occupied_d[free_idx] = 1'b1;
                  res_o.ev             = EV_ALLOC;
                  res_o.slot_index     = free_ext[2:0];
                end else begin
                  res_o.ev = EV_FULL;
                end
              end
            end
            OP_START: begin
              if (!res_full_i) begin
                res_push_o        = 1'b1;
                cmd_pop_o         = 1'b1;
                fast_d[start_idx]  = cmd_i.fast;
                armed_d[start_idx] = 1'b1;
                rem_we            = 1'b1;
                rem_waddr         = start_idx;
                rem_wdata         = cmd_i.delay;
                res_o.ev          = EV_START;
                res_o.slot_index  = cmd_i.slot;
                res_o.wrapped     = 1'b0;
                res_o.last        = 1'b1;
              end
            end
            OP_BAD_START: begin
              if (!res_full_i) begin
                res_push_o       = 1'b1;
                cmd_pop_o        = 1'b1;
                res_o.slot_index = cmd_i.slot;
                res_o.wrapped    = 1'b0;
                res_o.last       = 1'b1;
              end
            end
            OP_TICK: begin
              wrap_d  = (cnt_q == CNT_MAX);
              cnt_d   = (cnt_q == CNT_MAX) ? CNT_WRAP_TO : cnt_q + 30'd1;
              idx_d   = '0;
              state_d = ST_WALK;
            end
            OP_POLL: begin
              wrap_d  = 1'b0;
              idx_d   = '0;
              state_d = ST_WALK;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        res_o.slot_index = idx_ext[2:0];
        if (cmd_i.op == OP_TICK) begin
          res_o.ev  = EV_FIRE;
          need_push = armed_q[idx_q] && (rem_dec == '0) && fast_q[idx_q];
        end else begin
          res_o.ev  = EV_RUN;
          need_push = armed_q[idx_q] && (cur_rem == '0) && !fast_q[idx_q];
        end
        if (!(need_push && res_full_i)) begin
          res_push_o = need_push;
          if (cmd_i.op == OP_TICK) begin
            rem_we = armed_q[idx_q];
          end else if (need_push) begin
            armed_d[idx_q] = 1'b0;
          end
          if (idx_q == SW'(NUM_SLOTS - 1)) begin
            state_d = ST_DONE;
          end else begin
            idx_d = idx_q + SW'(1);
          end
        end
      end
      ST_DONE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          cmd_pop_o  = 1'b1;
          res_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      occupied_q <= '0;
      armed_q    <= '0;
      fast_q     <= '0;
      cnt_q      <= '0;
      wrap_q     <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      occupied_q <= occupied_d;
      armed_q    <= armed_d;
      fast_q     <= fast_d;
      cnt_q      <= cnt_d;
      wrap_q     <= wrap_d;
      idx_q      <= idx_d;
    end
  end

  // counts are read only while armed, so no reset
  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      remaining_q[rem_waddr] <= rem_wdata;
    end
  end

  assign walk_cmd_ok = !cmd_empty_i && (cmd_i.op == OP_TICK || cmd_i.op == OP_POLL);
  assign walk_begin  = (state_q == ST_IDLE) && (state_d == ST_WALK);

  `CTSP_ASSERT_IMPLIES(a_no_push_full, res_push_o, !res_full_i, "result pushed into full queue")
  `CTSP_ASSERT_IMPLIES(a_pop_last, cmd_pop_o, res_push_o && res_o.last, "retired without last word")
  `CTSP_ASSERT_IMPLIES(a_walk_op, state_q == ST_WALK, walk_cmd_ok, "walk without tick or poll")
  `CTSP_ASSERT_NEXT(a_walk_start, walk_begin, idx_q == '0, "walk not started at slot zero")

endmodule

`default_nettype wire
